/* src/u8dw_pkg.sv */
package u8dw_pkg;

   localparam int TOTAL_BITS = 16;
   localparam int RUN_BITS   = 16;
   localparam int CP_BITS    = 21;
   localparam int JOB_DEPTH  = 4;
   localparam int WIDE_SPANS = 13;

   localparam logic [CP_BITS-1:0] REPL_CP = 21'h00FFFD;

   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_CP,
      TAIL_TOTAL
   } tail_type;

   // replacement results first, then the optional tail result
   typedef struct packed {
      logic [2:0]         rep_count;
      tail_type           tail;
      logic [CP_BITS-1:0] cp;
      logic [1:0]         width;
   } job_type;

   localparam logic [CP_BITS-1:0] WIDE_LO [WIDE_SPANS] = '{
      21'h01100, 21'h02329, 21'h02E80, 21'h03040, 21'h0AC00, 21'h0F900, 21'h0FE10,
      21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h1F600, 21'h20000, 21'h30000
   };

   localparam logic [CP_BITS-1:0] WIDE_HI [WIDE_SPANS] = '{
      21'h0115F, 21'h0232A, 21'h0303E, 21'h0A4CF, 21'h0D7A3, 21'h0FAFF, 21'h0FE19,
      21'h0FE6F, 21'h0FF60, 21'h0FFE6, 21'h1F64F, 21'h2FFFD, 21'h3FFFD
   };

   function automatic logic [1:0] cp_width(input logic [CP_BITS-1:0] cp);
      logic [1:0] w;
      w = 2'd1;
      if (cp < 21'h80) begin
         w = (cp < 21'h20 || cp == 21'h7F) ? 2'd0 : 2'd1;
      end else if (cp == 21'h200B || cp == 21'h200C || cp == 21'h200D
                   || cp == 21'hFE0F) begin
         w = 2'd0;
      end else if (cp >= 21'h300) begin
         for (int i = 0; i < WIDE_SPANS; i++) begin
            if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) begin
               w = 2'd2;
            end
         end
      end
      return w;
   endfunction

endpackage

/* src/u8dw_front.sv */
module u8dw_front
   import u8dw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_op,
   input  logic [7:0] req_data_byte,
   input  logic       fifo_full,
   output logic       job_push,
   output job_type    job
);

   logic [1:0] held_count_ff, held_count_in;
   logic [2:0] exp_len_ff, exp_len_in;
   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic       accept;
   logic [2:0] lead_len;
   logic [2:0] rep;
   tail_type   tail;
   logic [CP_BITS-1:0] cp;
   logic       bad;

   // 1 ascii, 2..4 multibyte lead, 0 invalid
   always_comb begin
      priority if (req_data_byte[7] == 1'b0) begin
         lead_len = 3'd1;
      end else if (req_data_byte[7:5] == 3'b110) begin
         lead_len = 3'd2;
      end else if (req_data_byte[7:4] == 4'b1110) begin
         lead_len = 3'd3;
      end else if (req_data_byte[7:3] == 5'b11110) begin
         lead_len = 3'd4;
      end else begin
         lead_len = 3'd0;
      end
   end

   always_comb begin
      held_count_in = held_count_ff;
      exp_len_in    = exp_len_ff;
      held_in       = held_ff;
      rep           = 3'd0;
      tail          = TAIL_NONE;
      cp            = '0;
      bad           = 1'b0;
      if (req_op) begin
         rep           = {1'b0, held_count_ff};
         tail          = TAIL_TOTAL;
         held_count_in = 2'd0;
         exp_len_in    = 3'd0;
      end else if (held_count_ff == 2'd0 || req_data_byte[7:6] != 2'b10) begin
         // flush whatever is held, then read the byte as a lead
         rep           = {1'b0, held_count_ff};
         held_count_in = 2'd0;
         exp_len_in    = 3'd0;
         if (lead_len == 3'd1) begin
            tail = TAIL_CP;
            cp   = {13'd0, req_data_byte};
         end else if (lead_len == 3'd0) begin
            rep = rep + 3'd1;
         end else begin
            held_count_in = 2'd1;
            exp_len_in    = lead_len;
            held_in[0]    = req_data_byte;
         end
      end else if (({1'b0, held_count_ff} + 3'd1) < exp_len_ff) begin
         held_in[held_count_ff] = req_data_byte;
         held_count_in          = held_count_ff + 2'd1;
      end else begin
         unique case (exp_len_ff)
            3'd2: begin
               cp  = {10'd0, held_ff[0][4:0], req_data_byte[5:0]};
               bad = cp < 21'h80;
            end
            3'd3: begin
               cp  = {5'd0, held_ff[0][3:0], held_ff[1][5:0], req_data_byte[5:0]};
               bad = cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF);
            end
            default: begin
               cp  = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0],
                      req_data_byte[5:0]};
               bad = cp < 21'h10000 || cp > 21'h10FFFF;
            end
         endcase
         if (bad) begin
            rep = {1'b0, held_count_ff} + 3'd1;
         end else begin
            tail = TAIL_CP;
         end
         held_count_in = 2'd0;
         exp_len_in    = 3'd0;
      end
   end

   assign accept        = req_push && !fifo_full;
   assign job.rep_count = rep;
   assign job.tail      = tail;
   assign job.cp        = cp;
   assign job.width     = cp_width(cp);
   assign job_push      = accept && (rep != 3'd0 || tail != TAIL_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         exp_len_ff    <= 3'd0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         exp_len_ff    <= exp_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

/* src/u8dw_fifo.sv */
module u8dw_fifo
   import u8dw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type pop_data,
   output logic    full,
   output logic    empty
);

   localparam int PTR_BITS = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(JOB_DEPTH + 1);

   job_type              mem_ff [JOB_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic                 do_push, do_pop;

   assign full     = count_ff == CNT_BITS'(JOB_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/u8dw_back.sv */
module u8dw_back
   import u8dw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                job_ready,
   input  job_type             job,
   output logic                job_take,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic [CP_BITS-1:0]  rsp_code_point,
   output logic [1:0]          rsp_char_width,
   output logic [RUN_BITS-1:0] rsp_running_width,
   output logic                rsp_replaced,
   output logic                rsp_is_total,
   output logic                rsp_last
);

   logic                  cur_valid_ff;
   logic [2:0]            rem_ff;
   tail_type              tail_ff;
   logic [CP_BITS-1:0]    cp_ff;
   logic [1:0]            width_ff;
   logic [TOTAL_BITS-1:0] total_ff, total_in, sat_sum;
   logic [TOTAL_BITS:0]   sum;

   logic                  out_valid_ff;
   logic [CP_BITS-1:0]    out_cp_ff;
   logic [1:0]            out_width_ff;
   logic [RUN_BITS-1:0]   out_run_ff;
   logic                  out_rep_ff, out_total_ff, out_last_ff;

   logic                  load, emit, is_rep, is_last, is_tot;
   logic [CP_BITS-1:0]    res_cp;
   logic [1:0]            res_width;

   assign load    = !out_valid_ff || rsp_pop;
   assign emit    = cur_valid_ff && load;
   assign is_rep  = rem_ff != 3'd0;
   assign is_tot  = !is_rep && tail_ff == TAIL_TOTAL;
   assign is_last = is_rep ? (rem_ff == 3'd1 && tail_ff == TAIL_NONE) : 1'b1;
   assign res_cp  = is_rep ? REPL_CP : (is_tot ? '0 : cp_ff);
   assign res_width = is_rep ? 2'd1 : (is_tot ? 2'd0 : width_ff);

   // saturating width total
   assign sum      = {1'b0, total_ff} + {{(TOTAL_BITS - 1){1'b0}}, res_width};
   assign sat_sum  = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
   assign total_in = is_tot ? '0 : sat_sum;

   assign job_take = job_ready && (!cur_valid_ff || (emit && is_last));

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (job_take) begin
            cur_valid_ff <= 1'b1;
         end else if (emit && is_last) begin
            cur_valid_ff <= 1'b0;
         end
         if (emit) begin
            total_ff     <= total_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         rem_ff   <= job.rep_count;
         tail_ff  <= job.tail;
         cp_ff    <= job.cp;
         width_ff <= job.width;
      end else if (emit && is_rep) begin
         rem_ff <= rem_ff - 3'd1;
      end
      if (emit) begin
         out_cp_ff    <= res_cp;
         out_width_ff <= res_width;
         out_run_ff   <= RUN_BITS'(sat_sum);
         out_rep_ff   <= is_rep;
         out_total_ff <= is_tot;
         out_last_ff  <= is_last;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_code_point    = out_cp_ff;
   assign rsp_char_width    = out_width_ff;
   assign rsp_running_width = out_run_ff;
   assign rsp_replaced      = out_rep_ff;
   assign rsp_is_total      = out_total_ff;
   assign rsp_last          = out_last_ff;

endmodule

/* src/utf8_decode_width_stream_unit.sv */
// UTF-8 decoder with display width. Bytes enter one per cycle through the
// req_ queue port; each complete character leaves as one result with its code
// point, terminal width (0, 1 or 2) and the saturating running width total.
// Broken sequences, overlong forms, surrogates and values above U+10FFFF give
// one U+FFFD per byte involved; an end item (req_op high) flushes held bytes
// as U+FFFD and then gives the total, which is cleared. The front end takes
// one item every cycle while its 4-entry job queue has room; the back end
// writes one result per cycle while rsp_ is popped or empty, so an item that
// causes several results keeps it busy; the queue absorbs such bursts. A result
// passes the job queue, then the back end's current-job and output registers.
module utf8_decode_width_stream_unit
   import u8dw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_op,
   input  logic [7:0]          req_data_byte,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [CP_BITS-1:0]  rsp_code_point,
   output logic [1:0]          rsp_char_width,
   output logic [RUN_BITS-1:0] rsp_running_width,
   output logic                rsp_replaced,
   output logic                rsp_is_total,
   output logic                rsp_last
);

   logic    job_push, job_take, fifo_full, fifo_empty;
   job_type push_job, pop_job;

   assign req_full = fifo_full;

   u8dw_front front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .fifo_full     (fifo_full),
      .job_push      (job_push),
      .job           (push_job)
   );

   u8dw_fifo job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .pop       (job_take),
      .pop_data  (pop_job),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   u8dw_back back (
      .clock             (clock),
      .reset             (reset),
      .job_ready         (!fifo_empty),
      .job               (pop_job),
      .job_take          (job_take),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_code_point    (rsp_code_point),
      .rsp_char_width    (rsp_char_width),
      .rsp_running_width (rsp_running_width),
      .rsp_replaced      (rsp_replaced),
      .rsp_is_total      (rsp_is_total),
      .rsp_last          (rsp_last)
   );

   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting right after reset");

   a_total_shape : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_is_total |->
         rsp_code_point == '0 && rsp_char_width == 2'd0 && rsp_last && !rsp_replaced)
      else $error("malformed total result");

   a_repl_shape : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_replaced |-> rsp_code_point == REPL_CP && rsp_char_width == 2'd1)
      else $error("malformed replacement result");

   a_width_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_char_width != 2'd3)
      else $error("char width out of range");

endmodule

/* dv/utf8_decode_width_stream_unit_test.sv */
`timescale 1ns / 100ps

module utf8_decode_width_stream_unit_test;
   import u8dw_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int HOLD_CYCLES = 100;
   localparam int PHASE_ITEMS = 40;
   localparam logic [CP_BITS-1:0] REPLACEMENT = 21'h00FFFD;

   localparam logic [CP_BITS-1:0] EDGE_CPS [56] = '{
      21'h7F, 21'h80, 21'h2FF, 21'h300, 21'h7FF, 21'h800, 21'h10FF, 21'h1100,
      21'h115F, 21'h1160, 21'h200A, 21'h200B, 21'h200C, 21'h200D, 21'h200E,
      21'h2328, 21'h2329, 21'h232A, 21'h2E7F, 21'h2E80, 21'h303E, 21'h303F,
      21'h3040, 21'hA4CF, 21'hA4D0, 21'hABFF, 21'hAC00, 21'hD7A3, 21'hD7A4,
      21'hF8FF, 21'hF900, 21'hFAFF, 21'hFE0E, 21'hFE0F, 21'hFE10, 21'hFE19,
      21'hFE30, 21'hFE6F, 21'hFF00, 21'hFF60, 21'hFFE0, 21'hFFE6, 21'hFFFD,
      21'hFFFF, 21'h10000, 21'h1F5FF, 21'h1F600, 21'h1F64F, 21'h1F650,
      21'h20000, 21'h2FFFD, 21'h2FFFE, 21'h30000, 21'h3FFFD, 21'h3FFFE,
      21'h10FFFF
   };

   typedef struct packed {
      logic [CP_BITS-1:0]  cp;
      logic [1:0]          cols;
      logic [RUN_BITS-1:0] run;
      logic                rep;
      logic                tot;
      logic                lst;
   } char_type;

   typedef struct packed {
      logic       op;
      logic [7:0] b;
      logic       typed;
      char_type   want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic req_op = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [CP_BITS-1:0] rsp_code_point;
   logic [1:0] rsp_char_width;
   logic [RUN_BITS-1:0] rsp_running_width;
   logic rsp_replaced;
   logic rsp_is_total;
   logic rsp_last;

   logic hold_rx = 1'b0;
   int recv_idle = 0;
   int send_idle = 0;
   int sent = 0;

   // decoder state mirror
   logic [7:0] held_b [3];
   int held_n = 0;
   int need_len = 0;
   logic [TOTAL_BITS-1:0] width_sum = '0;

   char_type step_chars [$];
   char_type chars_due [$];
   script_row_type byte_script [$];
   int taken = 0;
   int quiet = 0;
   int errors = 0;

   utf8_decode_width_stream_unit dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_op(req_op),
      .req_data_byte(req_data_byte),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_code_point(rsp_code_point),
      .rsp_char_width(rsp_char_width),
      .rsp_running_width(rsp_running_width),
      .rsp_replaced(rsp_replaced),
      .rsp_is_total(rsp_is_total),
      .rsp_last(rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic is_wide(input logic [CP_BITS-1:0] cp);
      return (cp >= 21'h1100 && cp <= 21'h115F) || (cp >= 21'h2329 && cp <= 21'h232A)
         || (cp >= 21'h2E80 && cp <= 21'h303E) || (cp >= 21'h3040 && cp <= 21'hA4CF)
         || (cp >= 21'hAC00 && cp <= 21'hD7A3) || (cp >= 21'hF900 && cp <= 21'hFAFF)
         || (cp >= 21'hFE10 && cp <= 21'hFE19) || (cp >= 21'hFE30 && cp <= 21'hFE6F)
         || (cp >= 21'hFF00 && cp <= 21'hFF60) || (cp >= 21'hFFE0 && cp <= 21'hFFE6)
         || (cp >= 21'h1F600 && cp <= 21'h1F64F) || (cp >= 21'h20000 && cp <= 21'h2FFFD)
         || (cp >= 21'h30000 && cp <= 21'h3FFFD);
   endfunction

   function automatic logic [1:0] cols_of(input logic [CP_BITS-1:0] cp);
      logic [1:0] c;
      if (cp < 21'h80) begin
         c = (cp < 21'h20 || cp == 21'h7F) ? 2'd0 : 2'd1;
      end else if (cp == 21'h200B || cp == 21'h200C || cp == 21'h200D || cp == 21'hFE0F) begin
         c = 2'd0;
      end else if (cp >= 21'h300 && is_wide(cp)) begin
         c = 2'd2;
      end else begin
         c = 2'd1;
      end
      return c;
   endfunction

   task automatic note_char(input logic [CP_BITS-1:0] cp, input logic rep);
      char_type c;
      logic [TOTAL_BITS:0] sum;
      c = '0;
      c.cp = cp;
      c.cols = cols_of(cp);
      sum = {1'b0, width_sum} + c.cols;
      width_sum = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
      c.run = RUN_BITS'(width_sum);
      c.rep = rep;
      step_chars.push_back(c);
   endtask

   task automatic flush_partial();
      for (int i = 0; i < held_n; i++) begin
         note_char(REPLACEMENT, 1'b1);
      end
      held_n = 0;
      need_len = 0;
   endtask

   task automatic start_char(input logic [7:0] b);
      if (b < 8'h80) begin
         note_char({13'd0, b}, 1'b0);
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
         need_len = (b[7:5] == 3'b110) ? 2 : (b[7:4] == 4'b1110) ? 3 : 4;
         held_b[0] = b;
         held_n = 1;
      end else begin
         note_char(REPLACEMENT, 1'b1);
      end
   endtask

   task automatic extend_char(input logic [7:0] b);
      logic [CP_BITS-1:0] cp;
      logic bad;
      if (held_n + 1 < need_len) begin
         held_b[2'(held_n)] = b;
         held_n++;
      end else begin
         case (need_len)
            2: begin
               cp = {10'd0, held_b[0][4:0], b[5:0]};
               bad = cp < 21'h80;
            end
            3: begin
               cp = {5'd0, held_b[0][3:0], held_b[1][5:0], b[5:0]};
               bad = cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF);
            end
            default: begin
               cp = {held_b[0][2:0], held_b[1][5:0], held_b[2][5:0], b[5:0]};
               bad = cp < 21'h10000 || cp > 21'h10FFFF;
            end
         endcase
         if (bad) begin
            for (int i = 0; i <= held_n; i++) begin
               note_char(REPLACEMENT, 1'b1);
            end
         end else begin
            note_char(cp, 1'b0);
         end
         held_n = 0;
         need_len = 0;
      end
   endtask

   task automatic decode_item(input logic op, input logic [7:0] b);
      char_type c;
      step_chars.delete();
      if (op) begin
         flush_partial();
         c = '0;
         c.run = RUN_BITS'(width_sum);
         c.tot = 1'b1;
         step_chars.push_back(c);
         width_sum = '0;
      end else if (held_n == 0) begin
         start_char(b);
      end else if (b[7:6] == 2'b10) begin
         extend_char(b);
      end else begin
         flush_partial();
         start_char(b);
      end
      if (step_chars.size() > 0) begin
         c = step_chars[step_chars.size() - 1];
         c.lst = 1'b1;
         step_chars[step_chars.size() - 1] = c;
      end
   endtask

   task automatic match_field(input string fname, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      char_type want;
      logic moved;
      moved = 1'b0;
      if (reset) begin
         held_n = 0;
         need_len = 0;
         width_sum = '0;
         chars_due.delete();
         taken = 0;
         quiet = 0;
      end else begin
         if (req_push && !req_full) begin
            decode_item(req_op, req_data_byte);
            if (taken < byte_script.size()) begin
               if (byte_script[taken].typed) begin
                  step_chars.delete();
                  step_chars.push_back(byte_script[taken].want);
               end
            end
            foreach (step_chars[i]) chars_due.push_back(step_chars[i]);
            taken++;
            moved = 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            moved = 1'b1;
            if (chars_due.size() == 0) begin
               $display("%0t: unexpected transfer expected none got cp %0h", $time,
                        rsp_code_point);
               errors++;
            end else begin
               want = chars_due.pop_front();
               match_field("code_point", want.cp, rsp_code_point);
               match_field("char_width", want.cols, rsp_char_width);
               match_field("running_width", want.run, rsp_running_width);
               match_field("replaced", want.rep, rsp_replaced);
               match_field("is_total", want.tot, rsp_is_total);
               match_field("last", want.lst, rsp_last);
            end
         end
         if (moved) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
               $display("utf8_decode_width_stream_unit_test NOT OK");
               $finish;
            end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_rx) begin
            hold_rx <= 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   function automatic int len_for(input logic [CP_BITS-1:0] cp);
      return (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
   endfunction

   function automatic logic [7:0] enc_byte(input logic [CP_BITS-1:0] cp, input int len,
                                           input int idx);
      logic [CP_BITS-1:0] part;
      if (idx > 0) begin
         part = cp >> (6 * (len - 1 - idx));
         return {2'b10, part[5:0]};
      end
      case (len)
         1: return cp[7:0];
         2: return {3'b110, cp[10:6]};
         3: return {4'b1110, cp[15:12]};
         default: return {5'b11110, cp[20:18]};
      endcase
   endfunction

   task automatic send_byte(input logic op, input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_op <= op;
      req_data_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sent++;
   endtask

   task automatic send_char(input logic [CP_BITS-1:0] cp, input int len, input int count);
      for (int i = 0; i < count; i++) begin
         send_byte(1'b0, enc_byte(cp, len, i));
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(negedge clock); while (chars_due.size() != 0);
      @(posedge clock);
   endtask

   task automatic add_row(input logic op, input logic [7:0] b, input logic typed,
                          input logic [CP_BITS-1:0] cp, input logic [1:0] cols,
                          input logic [RUN_BITS-1:0] run, input logic rep,
                          input logic tot);
      script_row_type r;
      r.op = op;
      r.b = b;
      r.typed = typed;
      r.want.cp = cp;
      r.want.cols = cols;
      r.want.run = run;
      r.want.rep = rep;
      r.want.tot = tot;
      r.want.lst = 1'b1;
      byte_script.push_back(r);
   endtask

   task automatic random_text();
      int pick;
      int len;
      logic [CP_BITS-1:0] cp;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         case ($urandom_range(0, 9))
            0, 1: cp = CP_BITS'($urandom_range(0, 'h7F));
            2: cp = CP_BITS'($urandom_range('h80, 'h7FF));
            3, 4: begin
               cp = CP_BITS'($urandom_range('h800, 'hF7FF));
               if (cp >= 21'hD800) cp = cp + 21'h800;
            end
            5: cp = CP_BITS'($urandom_range('h10000, 'h10FFFF));
            default: cp = EDGE_CPS[6'($urandom_range(0, 55))];
         endcase
         len = len_for(cp);
         send_char(cp, len, len);
      end else if (pick < 62) begin
         send_byte(1'b0, 8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
         // cut-off sequence followed by a non-continuation or an end item
         cp = CP_BITS'($urandom_range('h80, 'h10FFFF));
         len = len_for(cp);
         send_char(cp, len, $urandom_range(1, len - 1));
         if ($urandom_range(0, 2) == 0) begin
            send_byte(1'b1, 8'($urandom_range(0, 255)));
         end else begin
            b = 8'($urandom_range(0, 255));
            while (b[7:6] == 2'b10) b = 8'($urandom_range(0, 255));
            send_byte(1'b0, b);
         end
      end else if (pick < 76) begin
         len = $urandom_range(2, 4);
         cp = CP_BITS'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
         send_char(cp, len, len);
      end else if (pick < 81) begin
         send_char(CP_BITS'($urandom_range('hD800, 'hDFFF)), 3, 3);
      end else if (pick < 86) begin
         send_char(CP_BITS'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
      end else if (pick < 92) begin
         repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom_range('h80, 'hBF)));
      end else begin
         send_byte(1'b1, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      add_row(1'b0, 8'h00, 1'b1, 21'h0, 2'd0, 16'd0, 1'b0, 1'b0);
      add_row(1'b0, 8'h41, 1'b1, 21'h41, 2'd1, 16'd1, 1'b0, 1'b0);
      add_row(1'b0, 8'h7F, 1'b1, 21'h7F, 2'd0, 16'd1, 1'b0, 1'b0);
      add_row(1'b0, 8'h80, 1'b1, REPLACEMENT, 2'd1, 16'd2, 1'b1, 1'b0);
      add_row(1'b0, 8'hFF, 1'b1, REPLACEMENT, 2'd1, 16'd3, 1'b1, 1'b0);
      add_row(1'b0, 8'hC3, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'hA9, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'hE2, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'h80, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'h8B, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'hEF, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'hBF, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'hBD, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'hF0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'h9F, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'h98, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'h80, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'hC0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'h80, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'hE2, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'h41, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'hED, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b0, 8'hA0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b1, 8'hFF, 1'b0, '0, '0, '0, 1'b0, 1'b0);
      add_row(1'b1, 8'h00, 1'b1, 21'h0, 2'd0, 16'd0, 1'b0, 1'b1);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle = 38;
      recv_idle <= 78;
      foreach (byte_script[i]) send_byte(byte_script[i].op, byte_script[i].b);
      sent = 0;
      while (sent < PHASE_ITEMS) random_text();

      // stall the receiver and offer 30 transfers, enough for the input to back up
      send_idle = 0;
      hold_rx <= 1'b1;
      repeat (30) send_byte(1'b0, 8'($urandom_range(0, 127)));
      wait_drained();

      send_idle = 78;
      recv_idle <= 38;
      sent = 0;
      while (sent < PHASE_ITEMS) random_text();

      send_idle = 0;
      recv_idle <= 0;
      sent = 0;
      while (sent < PHASE_ITEMS) random_text();

      send_char(21'h41, 1, 1);
      send_byte(1'b1, 8'h5A);
      sent = 0;
      while (sent < 20) random_text();

      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("utf8_decode_width_stream_unit_test OK");
      end else begin
         $display("utf8_decode_width_stream_unit_test NOT OK");
      end
      $finish;
   end

endmodule

/* utf8_decode_width_stream_unit.f */
src/u8dw_pkg.sv
src/u8dw_front.sv
src/u8dw_fifo.sv
src/u8dw_back.sv
src/utf8_decode_width_stream_unit.sv
dv/utf8_decode_width_stream_unit_test.sv
